// ----- hdl/pcfd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcfd_pkg: shared types and constants of the filtered-derivative pid block
// register indexes, datapath widths and the sequencer state codes
// ----------------------------------------------------------------------------
package pcfd_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [2:0] REG_INTEG_LIMIT = 3'd3;
	localparam logic [2:0] REG_OUT_LIMIT   = 3'd4;
	localparam logic [2:0] REG_FILT_COEF   = 3'd5;

	localparam int GAIN_W  = 16;
	localparam int LIMIT_W = 15;
	localparam int COEF_W  = 17;
	localparam int SAMP_W  = 16;
	localparam int ERR_W   = 17;
	localparam int ACC_W   = 32;
	localparam int DER_W   = 24;
	localparam int MUL_A_W = 18;
	localparam int MUL_B_W = 34;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int SUM_W   = 36;
	localparam int QUO_W   = LIMIT_W + 8;

	localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;

	// sequencer states, one-hot
	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_ACC  = 10'b00_0000_0010,
		ST_MULI = 10'b00_0000_0100,
		ST_CHKI = 10'b00_0000_1000,
		ST_DIV  = 10'b00_0001_0000,
		ST_MULD = 10'b00_0010_0000,
		ST_MULK = 10'b00_0100_0000,
		ST_MULF = 10'b00_1000_0000,
		ST_DSUM = 10'b01_0000_0000,
		ST_FIN  = 10'b10_0000_0000
	} state_t;

endpackage

// ----- hdl/pid_controller_filtered_derivative.sv -----
// ----------------------------------------------------------------------------
// pid_controller_filtered_derivative: pid controller with anti-windup
// one drive beat per sample beat, integral clamp and low-pass derivative
// ----------------------------------------------------------------------------
// Each input beat (setpoint, measurement) yields one drive beat. The work runs
// on one shared 18x34 signed multiplier under a small sequencer; the filter
// steps are skipped when the derivative gain is zero, and when the integral
// term clamps the accumulator is rewritten (limit / gain done by a restoring
// divider, one quotient bit per cycle). s_axis_tready is high only while the
// sequencer is idle, so the next sample is taken in the cycle after the output
// register is loaded at the earliest. A finished drive beat sits in the output
// register, so a new sample is taken while it waits, and the sequencer only
// stalls in its last step if the previous beat has still not been taken.
// Configuration writes are taken at any edge with cfg_we high and are meant
// to happen while the block is idle.
module pid_controller_filtered_derivative (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	// sample stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] setpoint, [31:16] measurement
	// drive stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [15:0] drive
);

	// configuration registers
	logic signed [pcfd_pkg::GAIN_W-1:0]  prop_gain_q;
	logic signed [pcfd_pkg::GAIN_W-1:0]  integ_gain_q;
	logic signed [pcfd_pkg::GAIN_W-1:0]  deriv_gain_q;
	logic        [pcfd_pkg::LIMIT_W-1:0] integ_limit_q;
	logic        [pcfd_pkg::LIMIT_W-1:0] output_limit_q;
	logic        [pcfd_pkg::COEF_W-1:0]  filt_coef_q;

	// controller state
	logic signed [pcfd_pkg::ACC_W-1:0] acc_q;
	logic signed [pcfd_pkg::ERR_W-1:0] prev_err_q;
	logic signed [pcfd_pkg::DER_W-1:0] prev_der_q;

	// working registers
	pcfd_pkg::state_t                   state_q;
	logic signed [pcfd_pkg::ERR_W-1:0]  err_q;
	logic signed [pcfd_pkg::PROD_W-1:0] prod_q;
	logic signed [pcfd_pkg::PROD_W-1:0] filt_q;
	logic signed [pcfd_pkg::SUM_W-1:0]  sum_q;
	logic        [pcfd_pkg::QUO_W-1:0]  dvd_q;    // dividend, becomes quotient
	logic        [pcfd_pkg::COEF_W-1:0] rem_q;
	logic        [pcfd_pkg::COEF_W-1:0] dvsr_q;
	logic                               neg_q;
	logic        [4:0]                  div_cnt_q;

	// output register
	logic                              out_valid_q;
	logic signed [pcfd_pkg::SAMP_W-1:0] drive_q;

	// ------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			integ_limit_q  <= '0;
			output_limit_q <= '0;
			filt_coef_q    <= pcfd_pkg::COEF_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				pcfd_pkg::REG_PROP_GAIN:   prop_gain_q    <= cfg_data[15:0];
				pcfd_pkg::REG_INTEG_GAIN:  integ_gain_q   <= cfg_data[15:0];
				pcfd_pkg::REG_DERIV_GAIN:  deriv_gain_q   <= cfg_data[15:0];
				pcfd_pkg::REG_INTEG_LIMIT: integ_limit_q  <= cfg_data[14:0];
				pcfd_pkg::REG_OUT_LIMIT:   output_limit_q <= cfg_data[14:0];
				pcfd_pkg::REG_FILT_COEF:   filt_coef_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// datapath helpers
	// ------------------------------------------------------------------
	logic signed [pcfd_pkg::SAMP_W-1:0] setpoint, measurement;
	assign setpoint    = s_axis_tdata[15:0];
	assign measurement = s_axis_tdata[31:16];

	// filter weight, above one acts as one
	logic [pcfd_pkg::COEF_W-1:0] k_clamped, k_inv;
	assign k_clamped = (filt_coef_q > pcfd_pkg::COEF_ONE) ? pcfd_pkg::COEF_ONE : filt_coef_q;
	assign k_inv     = pcfd_pkg::COEF_ONE - k_clamped;

	// error change for the derivative
	logic signed [pcfd_pkg::ERR_W:0] err_diff;
	assign err_diff = {err_q[pcfd_pkg::ERR_W-1], err_q}
		- {prev_err_q[pcfd_pkg::ERR_W-1], prev_err_q};

	// shared multiplier, operands picked by the sequencer
	logic signed [pcfd_pkg::MUL_A_W-1:0] mul_a;
	logic signed [pcfd_pkg::MUL_B_W-1:0] mul_b;
	logic signed [pcfd_pkg::PROD_W-1:0]  mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			pcfd_pkg::ST_ACC: begin
				mul_a = pcfd_pkg::MUL_A_W'(prop_gain_q);
				mul_b = pcfd_pkg::MUL_B_W'(err_q);
			end
			pcfd_pkg::ST_MULI: begin
				mul_a = pcfd_pkg::MUL_A_W'(integ_gain_q);
				mul_b = pcfd_pkg::MUL_B_W'(acc_q);
			end
			pcfd_pkg::ST_MULD: begin
				mul_a = pcfd_pkg::MUL_A_W'(deriv_gain_q);
				mul_b = pcfd_pkg::MUL_B_W'(err_diff);
			end
			pcfd_pkg::ST_MULK: begin
				mul_a = {1'b0, k_clamped};
				mul_b = prod_q[pcfd_pkg::MUL_B_W-1:0];   // raw derivative
			end
			pcfd_pkg::ST_MULF: begin
				mul_a = {1'b0, k_inv};
				mul_b = pcfd_pkg::MUL_B_W'(prev_der_q);
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// accumulator update, saturated to 32 bits
	logic signed [pcfd_pkg::ACC_W:0]   acc_sum;
	logic signed [pcfd_pkg::ACC_W-1:0] acc_sat;
	assign acc_sum = {acc_q[pcfd_pkg::ACC_W-1], acc_q} + (pcfd_pkg::ACC_W+1)'(err_q);
	always_comb begin
		if (acc_sum[pcfd_pkg::ACC_W] != acc_sum[pcfd_pkg::ACC_W-1])
			acc_sat = acc_sum[pcfd_pkg::ACC_W] ? {1'b1, {(pcfd_pkg::ACC_W-1){1'b0}}}
				: {1'b0, {(pcfd_pkg::ACC_W-1){1'b1}}};
		else
			acc_sat = acc_sum[pcfd_pkg::ACC_W-1:0];
	end

	// integral limit in q.8
	logic signed [pcfd_pkg::PROD_W-1:0] ilim_pos, ilim_neg;
	assign ilim_pos = {{(pcfd_pkg::PROD_W-pcfd_pkg::QUO_W){1'b0}}, integ_limit_q, 8'h00};
	assign ilim_neg = -ilim_pos;

	// divisor magnitude of the integral gain
	logic signed [pcfd_pkg::COEF_W-1:0] igain_ext;
	logic        [pcfd_pkg::COEF_W-1:0] igain_abs;
	assign igain_ext = pcfd_pkg::COEF_W'(integ_gain_q);
	assign igain_abs = igain_ext[pcfd_pkg::COEF_W-1] ? -igain_ext : igain_ext;

	// restoring divide step
	logic [pcfd_pkg::COEF_W-1:0] rem_sh, rem_nx;
	logic                        fits;
	logic [pcfd_pkg::QUO_W-1:0]  dvd_nx;
	logic signed [pcfd_pkg::ACC_W-1:0] quo_ext;
	assign rem_sh  = {rem_q[pcfd_pkg::COEF_W-2:0], dvd_q[pcfd_pkg::QUO_W-1]};
	assign fits    = rem_sh >= dvsr_q;
	assign rem_nx  = fits ? rem_sh - dvsr_q : rem_sh;
	assign dvd_nx  = {dvd_q[pcfd_pkg::QUO_W-2:0], fits};
	assign quo_ext = {{(pcfd_pkg::ACC_W-pcfd_pkg::QUO_W){1'b0}}, dvd_nx};

	// filtered derivative: floor of the weighted sum over 65536, saturated
	logic signed [pcfd_pkg::PROD_W-1:0] der_sum;
	logic signed [pcfd_pkg::PROD_W-17:0] der_flr;
	logic signed [pcfd_pkg::DER_W-1:0]  der_sat;
	localparam logic signed [pcfd_pkg::PROD_W-17:0] DER_MAX =
		(pcfd_pkg::PROD_W-16)'({1'b0, {(pcfd_pkg::DER_W-1){1'b1}}});
	localparam logic signed [pcfd_pkg::PROD_W-17:0] DER_MIN = -DER_MAX - 1;
	assign der_sum = filt_q + prod_q;
	assign der_flr = der_sum[pcfd_pkg::PROD_W-1:16];
	always_comb begin
		if (der_flr > DER_MAX)
			der_sat = DER_MAX[pcfd_pkg::DER_W-1:0];
		else if (der_flr < DER_MIN)
			der_sat = DER_MIN[pcfd_pkg::DER_W-1:0];
		else
			der_sat = der_flr[pcfd_pkg::DER_W-1:0];
	end

	// rounding half up to output units and clamp
	logic signed [pcfd_pkg::SUM_W-1:0] sum_rnd;
	logic signed [pcfd_pkg::SUM_W-9:0] drv_full, olim_pos, olim_neg;
	logic signed [pcfd_pkg::SAMP_W-1:0] drv_clamped;
	assign sum_rnd  = sum_q + pcfd_pkg::SUM_W'(128);
	assign drv_full = sum_rnd[pcfd_pkg::SUM_W-1:8];
	assign olim_pos = (pcfd_pkg::SUM_W-8)'(output_limit_q);
	assign olim_neg = -olim_pos;
	always_comb begin
		if (drv_full > olim_pos)
			drv_clamped = olim_pos[pcfd_pkg::SAMP_W-1:0];
		else if (drv_full < olim_neg)
			drv_clamped = olim_neg[pcfd_pkg::SAMP_W-1:0];
		else
			drv_clamped = drv_full[pcfd_pkg::SAMP_W-1:0];
	end

	logic out_free;
	assign out_free = !out_valid_q || m_axis_tready;

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcfd_pkg::ST_IDLE;
			acc_q       <= '0;
			prev_err_q  <= '0;
			prev_der_q  <= '0;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			// a new drive beat replaces one being taken in the same cycle
			if (state_q == pcfd_pkg::ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready)
				out_valid_q <= 1'b0;

			case (state_q)
				pcfd_pkg::ST_IDLE: begin
					if (s_axis_tvalid)
						state_q <= pcfd_pkg::ST_ACC;
				end
				pcfd_pkg::ST_ACC: begin
					acc_q   <= acc_sat;
					state_q <= pcfd_pkg::ST_MULI;      // prop product in flight
				end
				pcfd_pkg::ST_MULI: begin
					state_q <= pcfd_pkg::ST_CHKI;      // integral product in flight
				end
				pcfd_pkg::ST_CHKI: begin
					// clamp: rewrite the accumulator through the divider
					if (integ_gain_q != '0 && (prod_q > ilim_pos || prod_q < ilim_neg)) begin
						div_cnt_q <= '0;
						state_q   <= pcfd_pkg::ST_DIV;
					end else begin
						state_q <= pcfd_pkg::ST_MULD;
					end
				end
				pcfd_pkg::ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(pcfd_pkg::QUO_W - 1)) begin
						acc_q   <= neg_q ? -quo_ext : quo_ext;
						state_q <= pcfd_pkg::ST_MULD;
					end
				end
				pcfd_pkg::ST_MULD: begin
					// zero gain: derivative term off, filter memory held
					state_q <= (deriv_gain_q == '0) ? pcfd_pkg::ST_FIN : pcfd_pkg::ST_MULK;
				end
				pcfd_pkg::ST_MULK: state_q <= pcfd_pkg::ST_MULF;
				pcfd_pkg::ST_MULF: state_q <= pcfd_pkg::ST_DSUM;
				pcfd_pkg::ST_DSUM: begin
					prev_der_q <= der_sat;
					state_q    <= pcfd_pkg::ST_FIN;
				end
				pcfd_pkg::ST_FIN: begin
					if (out_free) begin
						prev_err_q <= err_q;
						state_q    <= pcfd_pkg::ST_IDLE;
					end
				end
				default: state_q <= pcfd_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers of the datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		case (state_q)
			pcfd_pkg::ST_IDLE: begin
				err_q <= pcfd_pkg::ERR_W'(setpoint) - pcfd_pkg::ERR_W'(measurement);
			end
			pcfd_pkg::ST_MULI: begin
				sum_q <= prod_q[pcfd_pkg::SUM_W-1:0];     // proportional term
			end
			pcfd_pkg::ST_CHKI: begin
				dvd_q  <= {integ_limit_q, 8'h00};
				rem_q  <= '0;
				dvsr_q <= igain_abs;
				if (integ_gain_q != '0) begin
					if (prod_q > ilim_pos) begin
						sum_q <= sum_q + ilim_pos[pcfd_pkg::SUM_W-1:0];
						neg_q <= integ_gain_q[pcfd_pkg::GAIN_W-1];
					end else if (prod_q < ilim_neg) begin
						sum_q <= sum_q + ilim_neg[pcfd_pkg::SUM_W-1:0];
						neg_q <= !integ_gain_q[pcfd_pkg::GAIN_W-1];
					end else begin
						sum_q <= sum_q + prod_q[pcfd_pkg::SUM_W-1:0];
					end
				end
			end
			pcfd_pkg::ST_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= dvd_nx;
			end
			pcfd_pkg::ST_MULF: begin
				filt_q <= prod_q;                          // k * raw
			end
			pcfd_pkg::ST_DSUM: begin
				sum_q <= sum_q + pcfd_pkg::SUM_W'(der_sat);
			end
			pcfd_pkg::ST_FIN: begin
				if (out_free)
					drive_q <= drv_clamped;
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == pcfd_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = drive_q;

endmodule

// ----- tb/pid_drive_checker.sv -----
// ----------------------------------------------------------------------------
// pid_drive_checker: drive prediction and comparison for the pid block
// follows register writes and sample beats, predicts each drive value in
// exact fixed point and compares it with the drive beats in order
// ----------------------------------------------------------------------------
module pid_drive_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] setpoint, [31:16] measurement
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // [15:0] drive
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic signed [pcfd_pkg::SAMP_W-1:0] measurement;
		logic signed [pcfd_pkg::SAMP_W-1:0] setpoint;
	} sample_t;

	localparam longint ACC_HI = 64'sd2147483647;
	localparam longint ACC_LO = -64'sd2147483648;
	localparam longint DER_HI = 64'sd8388607;
	localparam longint DER_LO = -64'sd8388608;

	// register copies
	logic signed [pcfd_pkg::GAIN_W-1:0] kp, ki, kd;
	logic [pcfd_pkg::LIMIT_W-1:0]       integ_lim, out_lim;
	logic [pcfd_pkg::COEF_W-1:0]        filt_coef;

	// controller state
	logic signed [pcfd_pkg::ACC_W-1:0] err_sum;
	logic signed [pcfd_pkg::ERR_W-1:0] last_err;
	logic signed [pcfd_pkg::DER_W-1:0] filt_deriv;

	logic signed [15:0] expected_drive[$];
	logic signed [15:0] want;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// one controller step; updates the state copies, returns the drive value
	function automatic logic signed [15:0] next_drive(input sample_t smp);
		longint err, p, i, d, t, lim, raw, k, acc, total, drv;
		err = longint'(smp.setpoint) - longint'(smp.measurement);
		p = longint'(kp) * err;
		acc = longint'(err_sum) + err;
		if (acc > ACC_HI) acc = ACC_HI;
		if (acc < ACC_LO) acc = ACC_LO;
		i = 0;
		if (ki != 0) begin
			t = longint'(ki) * acc;
			lim = longint'(integ_lim) * 256;
			if (t > lim) begin
				i = lim;
				acc = lim / longint'(ki);
			end else if (t < -lim) begin
				i = -lim;
				acc = -lim / longint'(ki);
			end else begin
				i = t;
			end
		end
		err_sum = acc[pcfd_pkg::ACC_W-1:0];
		d = 0;
		if (kd != 0) begin
			raw = longint'(kd) * (err - longint'(last_err));
			k = (filt_coef > pcfd_pkg::COEF_ONE) ? longint'(pcfd_pkg::COEF_ONE)
				: longint'(filt_coef);
			d = (k * raw + (longint'(pcfd_pkg::COEF_ONE) - k) * longint'(filt_deriv)) >>> 16;
			if (d > DER_HI) d = DER_HI;
			if (d < DER_LO) d = DER_LO;
			filt_deriv = d[pcfd_pkg::DER_W-1:0];
		end
		last_err = err[pcfd_pkg::ERR_W-1:0];
		total = p + i + d;
		drv = (total + 128) >>> 8;
		if (drv > longint'(out_lim)) drv = longint'(out_lim);
		if (drv < -longint'(out_lim)) drv = -longint'(out_lim);
		return drv[15:0];
	endfunction

	// one line per mismatch
	task automatic report_mismatch(input string msg);
		$display("%0t drive check: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = '0;
			ki = '0;
			kd = '0;
			integ_lim = '0;
			out_lim = '0;
			filt_coef = pcfd_pkg::COEF_ONE;
			err_sum = '0;
			last_err = '0;
			filt_deriv = '0;
			expected_drive.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pcfd_pkg::REG_PROP_GAIN:   kp = cfg_data[pcfd_pkg::GAIN_W-1:0];
					pcfd_pkg::REG_INTEG_GAIN:  ki = cfg_data[pcfd_pkg::GAIN_W-1:0];
					pcfd_pkg::REG_DERIV_GAIN:  kd = cfg_data[pcfd_pkg::GAIN_W-1:0];
					pcfd_pkg::REG_INTEG_LIMIT: integ_lim = cfg_data[pcfd_pkg::LIMIT_W-1:0];
					pcfd_pkg::REG_OUT_LIMIT:   out_lim = cfg_data[pcfd_pkg::LIMIT_W-1:0];
					pcfd_pkg::REG_FILT_COEF:   filt_coef = cfg_data[pcfd_pkg::COEF_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_drive.push_back(next_drive(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_drive.size() == 0) begin
					report_mismatch($sformatf("drive beat %0d with no sample outstanding",
						$signed(m_axis_tdata)));
				end else begin
					want = expected_drive.pop_front();
					if (m_axis_tdata !== want)
						report_mismatch($sformatf("drive got %0d, want %0d",
							$signed(m_axis_tdata), want));
				end
			end
			pending = expected_drive.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: regression bench for the filtered-derivative pid controller
// drives register settings and sample beats with random gaps and output
// stalls; a checker beside the block predicts every drive beat
// ----------------------------------------------------------------------------
module tb;

	typedef struct packed {
		logic signed [pcfd_pkg::SAMP_W-1:0] measurement;
		logic signed [pcfd_pkg::SAMP_W-1:0] setpoint;
	} sample_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [16:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [15:0] setpoint, [31:16] measurement
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [15:0] drive

	int fail_count;
	int pending;
	bit quiet;      // no gaps and no stalls while set
	int gap_odds;   // 0: no sender gaps, else one gap per gap_odds+1 beats on average

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	pid_controller_filtered_derivative u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	pid_drive_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// one register write, taken at the next rising edge
	task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic apply_setting(input logic [16:0] kp, ki, kd, ilim, olim, coef);
		write_reg(pcfd_pkg::REG_PROP_GAIN, kp);
		write_reg(pcfd_pkg::REG_INTEG_GAIN, ki);
		write_reg(pcfd_pkg::REG_DERIV_GAIN, kd);
		write_reg(pcfd_pkg::REG_INTEG_LIMIT, ilim);
		write_reg(pcfd_pkg::REG_OUT_LIMIT, olim);
		write_reg(pcfd_pkg::REG_FILT_COEF, coef);
	endtask

	// one sample beat; tvalid stays up afterwards unless a gap comes next
	task automatic send_sample(input logic signed [15:0] sp, ms);
		sample_t smp;
		if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		smp.setpoint = sp;
		smp.measurement = ms;
		s_axis_tdata = smp;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// wait until every drive beat is back, then let the sequencer run out
	task automatic settle();
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// gains lean on zero, the two extremes and a band of small values
	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'h8000;
			2: return 16'h7FFF;
			3: return 16'($urandom_range(0, 2047)) - 16'd1024;
			default: return 16'($urandom);
		endcase
	endfunction

	// the random case sets the unused upper bits too
	function automatic logic [16:0] pick_limit();
		case ($urandom_range(0, 4))
			0: return 17'h00000;
			1: return 17'h07FFF;
			2: return 17'($urandom);
			3: return 17'($urandom_range(0, 2000));
			default: return 17'($urandom_range(0, 32767));
		endcase
	endfunction

	// coefficients above one are legal and act as one
	function automatic logic [16:0] pick_coef();
		case ($urandom_range(0, 4))
			0: return 17'h00000;
			1: return pcfd_pkg::COEF_ONE;
			2: return 17'h1FFFF;
			3: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(0, 65536));
		endcase
	endfunction

	function automatic logic [15:0] pick_edge();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// drive side: ready runs of random length, broken by stall bursts
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			m_axis_tready = 1'b1;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			if (!quiet) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
		end
	end

	initial begin
		int lvl;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pcfd_pkg::REG_PROP_GAIN;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		quiet = 1'b0;
		gap_odds = 3;
		lvl = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// unity proportional gain alone: error extremes and clamping
		apply_setting(17'h00100, 17'h00000, 17'h00000, 17'h07FFF, 17'h07FFF,
			pcfd_pkg::COEF_ONE);
		send_sample(16'h7FFF, 16'h8000);
		send_sample(16'h8000, 16'h7FFF);
		send_sample(16'h0000, 16'h0000);
		send_sample(16'sd100, -16'sd100);
		send_sample(-16'sd1, 16'sd0);
		send_sample(16'sd1, 16'sd1);
		settle();

		// half gain for the rounding, zero integral limit, filter weight
		// above one
		apply_setting(17'h00080, 17'h00100, 17'h00100, 17'h00000, 17'h07FFF, 17'h1FFFF);
		send_sample(16'sd1, 16'sd0);
		send_sample(16'sd0, 16'sd1);
		send_sample(16'h7FFF, 16'h8000);
		send_sample(16'h8000, 16'h7FFF);
		send_sample(16'sd5, 16'sd5);
		settle();

		// zero output limit with extreme gains and no filtering weight
		apply_setting(17'h08000, 17'h07FFF, 17'h08000, 17'h07FFF, 17'h00000, 17'h00000);
		send_sample(16'h7FFF, 16'h8000);
		send_sample(16'h8000, 16'h7FFF);
		send_sample(16'sd100, 16'sd0);
		send_sample(16'sd0, 16'sd0);
		settle();

		// most negative integral gain against a small limit, half filtering
		apply_setting(17'h00000, 17'h08000, 17'h07FFF, 17'd100, 17'h07FFF, 17'h08000);
		send_sample(16'sd10, 16'sd0);
		send_sample(16'sd0, 16'sd10);
		send_sample(-16'sd300, 16'sd0);
		send_sample(16'h7FFF, 16'h0000);
		send_sample(16'sd0, 16'sd0);
		settle();

		// random settings, each followed by a run of samples; the last run
		// goes without gaps or stalls
		for (int ph = 0; ph < 8; ph++) begin
			quiet = (ph == 7);
			gap_odds = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
			apply_setting({1'($urandom), pick_gain()}, {1'($urandom), pick_gain()},
				{1'($urandom), pick_gain()}, pick_limit(), pick_limit(), pick_coef());
			repeat (50) begin
				case ($urandom_range(0, 3))
					0: send_sample(16'($urandom), 16'($urandom));
					1: send_sample(pick_edge(), pick_edge());
					default: begin
						// a slowly moving setpoint with the measurement nearby
						lvl = lvl + int'($urandom_range(0, 64)) - 32;
						if (lvl > 30000 || lvl < -30000) lvl = 0;
						send_sample(16'(lvl), 16'(lvl + int'($urandom_range(0, 400)) - 200));
					end
				endcase
			end
			settle();
		end

		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
